### sv/evd_pkg.sv
package evd_pkg;

	// Command codes sampled on the first byte of a number
	localparam logic [1:0] MODE_ID   = 2'd0;
	localparam logic [1:0] MODE_LEN  = 2'd1;
	localparam logic [1:0] MODE_UINT = 2'd2;

	localparam logic [3:0] ID_MAX_BYTES  = 4'd4;
	localparam logic [3:0] LEN_MAX_BYTES = 4'd8;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Unknown-size value: 2^56 - 1
	localparam logic [63:0] UNKNOWN_VALUE = {8'h00, {56{1'b1}}};

	// One classified byte handed from front to back
	typedef struct packed {
		logic       first;  // first byte of a number
		logic       err;    // first byte that fails; yields an error item
		logic       last;   // number completes on this byte
		logic [1:0] mode;
		logic [3:0] len;    // total bytes, valid on first byte
		logic [7:0] data;   // byte with marker already cleared in length mode
	} entry_t;

	// All-ones payload of a length-mode number of n bytes: 7*n ones
	function automatic logic [63:0] len_ones(input logic [3:0] n);
		logic [63:0] m;
		m = '0;
		case (n)
			4'd1:    m = {57'd0, {7{1'b1}}};
			4'd2:    m = {50'd0, {14{1'b1}}};
			4'd3:    m = {43'd0, {21{1'b1}}};
			4'd4:    m = {36'd0, {28{1'b1}}};
			4'd5:    m = {29'd0, {35{1'b1}}};
			4'd6:    m = {22'd0, {42{1'b1}}};
			4'd7:    m = {15'd0, {49{1'b1}}};
			4'd8:    m = {8'd0, {56{1'b1}}};
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

### sv/evd_front.sv
module evd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              q_full,
	input  logic [7:0]        data_byte,
	input  logic [1:0]        command,
	input  logic [3:0]        uint_len,
	output logic              q_push,
	output evd_pkg::entry_t   q_entry
);

	logic [3:0] cnt_q;     // bytes still to come in the current number
	logic       first;
	logic       err;
	logic [3:0] lead_len;  // length from the leading one bit
	logic [3:0] len;
	logic [7:0] marker;
	logic [7:0] data;

	assign q_push = push && !q_full;
	assign first  = (cnt_q == 4'd0);

	// Leading-one position gives the length of id and length numbers
	always_comb begin
		lead_len = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (data_byte[i]) begin
				lead_len = 4'(8 - i);
			end
		end
	end

	// Classify the first byte
	always_comb begin
		err    = 1'b0;
		len    = lead_len;
		marker = 8'h80 >> (lead_len - 4'd1);
		data   = data_byte;
		case (command)
			evd_pkg::MODE_UINT: begin
				len = uint_len;
				err = (uint_len == 4'd0) || (uint_len > evd_pkg::LEN_MAX_BYTES);
			end
			evd_pkg::MODE_ID: begin
				err = (data_byte == 8'd0) || (lead_len > evd_pkg::ID_MAX_BYTES);
			end
			evd_pkg::MODE_LEN: begin
				err  = (data_byte == 8'd0);
				data = data_byte & ~marker;
			end
			default: err = 1'b1;
		endcase
	end

	always_comb begin
		q_entry.first = first;
		q_entry.err   = first && err;
		q_entry.mode  = command;
		q_entry.len   = len;
		q_entry.data  = first ? data : data_byte;
		q_entry.last  = first ? (err || len == 4'd1) : (cnt_q == 4'd1);
	end

	// Remaining-byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 4'd0;
		end else if (q_push) begin
			if (first) begin
				cnt_q <= err ? 4'd0 : len - 4'd1;
			end else begin
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end

endmodule

### sv/evd_queue.sv
module evd_queue #(
	parameter int DEPTH = evd_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  evd_pkg::entry_t wr_entry,
	output logic            full,
	input  logic            rd,
	output logic            avail,
	output evd_pkg::entry_t rd_entry
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	evd_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CW-1:0]   count_q;
	logic            do_wr;
	logic            do_rd;

	assign full     = (count_q == CW'(DEPTH));
	assign avail    = (count_q != '0);
	assign do_wr    = wr && !full;
	assign do_rd    = rd && avail;
	assign rd_entry = mem_q[rptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

### sv/evd_back.sv
module evd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_avail,
	input  evd_pkg::entry_t q_entry,
	output logic            q_pop,
	input  logic            pop,
	output logic            empty,
	output logic [63:0]     value,
	output logic [3:0]      num_bytes,
	output logic            status,
	output logic            unknown_size
);

	logic [63:0] acc_q;
	logic [3:0]  total_q;
	logic [1:0]  mode_q;
	logic        out_valid_q;
	logic [63:0] value_q;
	logic [3:0]  num_bytes_q;
	logic        status_q;
	logic        unknown_q;

	logic [63:0] nacc;
	logic [3:0]  ntot;
	logic [1:0]  nmode;
	logic        unk;

	// Take an entry when the output register is free or being drained
	assign q_pop = q_avail && (!out_valid_q || pop);

	// Accumulate next value
	always_comb begin
		if (q_entry.first) begin
			nacc  = {56'd0, q_entry.data};
			ntot  = q_entry.len;
			nmode = q_entry.mode;
		end else begin
			nacc  = {acc_q[55:0], q_entry.data};
			ntot  = total_q;
			nmode = mode_q;
		end
		unk = (nmode == evd_pkg::MODE_LEN) && (nacc == evd_pkg::len_ones(ntot));
	end

	// Accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			total_q <= '0;
			mode_q  <= evd_pkg::MODE_ID;
		end else if (q_pop && !q_entry.err) begin
			acc_q   <= nacc;
			total_q <= ntot;
			mode_q  <= nmode;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop && (q_entry.last || q_entry.err)) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && (q_entry.last || q_entry.err)) begin
			if (q_entry.err) begin
				value_q     <= '0;
				num_bytes_q <= 4'd0;
				status_q    <= 1'b1;
				unknown_q   <= 1'b0;
			end else begin
				value_q     <= unk ? evd_pkg::UNKNOWN_VALUE : nacc;
				num_bytes_q <= ntot;
				status_q    <= 1'b0;
				unknown_q   <= unk;
			end
		end
	end

	assign empty        = !out_valid_q;
	assign value        = value_q;
	assign num_bytes    = num_bytes_q;
	assign status       = status_q;
	assign unknown_size = unknown_q;

endmodule

### sv/ebml_vint_decoder.sv
// EBML variable-length integer decoder.
// Input channel: one stream byte per item (data_byte), with command and
// uint_len sampled on the first byte of each number. An item is taken on
// a rising edge with push high and full low.
// Result channel: the oldest result sits on value/num_bytes/status/
// unknown_size while empty is low and is taken on an edge with pop high.
// One result per completed number, or one error result at once for a bad
// first byte (zero marker, id longer than 4 bytes, bad uint_len, command 3).
// Throughput: one byte per cycle while full is low; the back end folds each byte
// into its accumulator by shift-and-or, and stalls while a result waits unpopped.
// A result is registered: its last byte enters the front/back queue on the
// accepting edge and moves into the output register once it is at the queue
// head and the output register is free or being popped.
// While a result waits in the output register with pop low, every byte
// stays in the queue; full rises within QUEUE_DEPTH more bytes and nothing
// is dropped.
// Reset clears the byte counter, queue and output valid flag; the block
// then expects the first byte of a new number.
module ebml_vint_decoder #(
	parameter int QUEUE_DEPTH = evd_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic [1:0]  command,
	input  logic [3:0]  uint_len,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] value,
	output logic [3:0]  num_bytes,
	output logic        status,
	output logic        unknown_size
);

	evd_pkg::entry_t wr_entry;
	evd_pkg::entry_t rd_entry;
	logic            q_push;
	logic            q_full;
	logic            q_pop;
	logic            q_avail;

	assign full = q_full;

	evd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.q_full    (q_full),
		.data_byte (data_byte),
		.command   (command),
		.uint_len  (uint_len),
		.q_push    (q_push),
		.q_entry   (wr_entry)
	);

	evd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_push),
		.wr_entry (wr_entry),
		.full     (q_full),
		.rd       (q_pop),
		.avail    (q_avail),
		.rd_entry (rd_entry)
	);

	evd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_avail      (q_avail),
		.q_entry      (rd_entry),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.value        (value),
		.num_bytes    (num_bytes),
		.status       (status),
		.unknown_size (unknown_size)
	);

endmodule

### tb/ebml_vint_decoder_tb.sv
`timescale 1ns / 1ps

module ebml_vint_decoder_tb;

	// Command value with no defined mode
	localparam logic [1:0] CMD_RESERVED = 2'd3;
	localparam int NUM_ITEMS   = 1350;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AFTER  = 50;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PRINT_CAP   = 100;

	typedef struct {
		logic [63:0] val;
		logic [3:0]  nbytes;
		logic        bad;
		logic        unknown;
	} vint_result_t;

	// Tracks the number being assembled and holds the results it must produce
	class vint_scoreboard;
		vint_result_t pending[$];
		logic [63:0]  acc;
		logic [3:0]   left;
		logic [3:0]   total;
		logic [1:0]   mode;
		int fails;
		int n_bytes;
		int n_checked;
		int n_errors;
		int n_unknown;

		function new();
			acc = '0;
			left = '0;
			total = '0;
			mode = evd_pkg::MODE_ID;
			fails = 0;
			n_bytes = 0;
			n_checked = 0;
			n_errors = 0;
			n_unknown = 0;
		endfunction

		// Bad first byte: error item, decoder stays idle
		function void reject_number();
			vint_result_t r;
			r.val = '0;
			r.nbytes = '0;
			r.bad = 1'b1;
			r.unknown = 1'b0;
			pending.push_back(r);
			acc = '0;
			left = '0;
			total = '0;
		endfunction

		// Last byte in: length mode maps an all-ones payload to unknown size
		function void close_number();
			vint_result_t r;
			logic [63:0]  ones;
			r.val = acc;
			r.nbytes = total;
			r.bad = 1'b0;
			r.unknown = 1'b0;
			if (mode == evd_pkg::MODE_LEN) begin
				ones = (64'd1 << (7 * total)) - 64'd1;
				if (acc == ones) begin
					r.val = evd_pkg::UNKNOWN_VALUE;
					r.unknown = 1'b1;
				end
			end
			pending.push_back(r);
			left = '0;
		endfunction

		function void note_byte(logic [7:0] b, logic [1:0] cmd, logic [3:0] ulen);
			int          pos;
			logic [3:0]  len;
			n_bytes++;
			// continuation byte: command and uint_len are ignored
			if (left != 0) begin
				acc = {acc[55:0], b};
				left = left - 4'd1;
				if (left == 0)
					close_number();
				return;
			end
			mode = cmd;
			if (cmd == evd_pkg::MODE_UINT) begin
				if (ulen == 0 || ulen > evd_pkg::LEN_MAX_BYTES) begin
					reject_number();
					return;
				end
				len = ulen;
				acc = {56'd0, b};
			end else if (cmd == evd_pkg::MODE_ID || cmd == evd_pkg::MODE_LEN) begin
				if (b == 8'd0) begin
					reject_number();
					return;
				end
				pos = 7;
				while (!b[pos])
					pos--;
				len = 4'(8 - pos);
				if (len > ((cmd == evd_pkg::MODE_ID) ? evd_pkg::ID_MAX_BYTES
						: evd_pkg::LEN_MAX_BYTES)) begin
					reject_number();
					return;
				end
				if (cmd == evd_pkg::MODE_ID)
					acc = {56'd0, b};
				else
					acc = {56'd0, b & ~(8'd1 << pos)};
			end else begin
				reject_number();
				return;
			end
			total = len;
			left = len - 4'd1;
			if (left == 0)
				close_number();
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			// keep the log short when everything goes wrong
			if (fails < PRINT_CAP)
				$display("%0t ERROR %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
			fails++;
		endtask

		task check_result(logic [63:0] v, logic [3:0] n, logic st, logic unk);
			vint_result_t want;
			if (pending.size() == 0) begin
				report("result with nothing pending, value", v, 64'd0);
				return;
			end
			want = pending.pop_front();
			n_checked++;
			if (want.bad)
				n_errors++;
			if (want.unknown)
				n_unknown++;
			if (v !== want.val)
				report("value", v, want.val);
			if (n !== want.nbytes)
				report("num_bytes", 64'(n), 64'(want.nbytes));
			if (st !== want.bad)
				report("status", 64'(st), 64'(want.bad));
			if (unk !== want.unknown)
				report("unknown_size", 64'(unk), 64'(want.unknown));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        pop = 1'b0;
	logic [7:0]  data_byte = '0;
	logic [1:0]  command = evd_pkg::MODE_ID;
	logic [3:0]  uint_len = '0;
	logic        full;
	logic        empty;
	logic [63:0] value;
	logic [3:0]  num_bytes;
	logic        status;
	logic        unknown_size;

	vint_scoreboard sb = new();
	int items_sent = 0;
	int results_taken = 0;
	int stall_cycles = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	bit hold_done = 1'b0;

	ebml_vint_decoder DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one item after a random gap; returns at the edge that takes it
	task automatic send_item(input logic [7:0] b, input logic [1:0] cmd, input logic [3:0] ulen);
		int gap;
		if ($urandom_range(0, 40) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 10);
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		command <= cmd;
		uint_len <= ulen;
		do @(posedge clk); while (full);
		items_sent++;
	endtask

	// First byte carries the command; later bytes get random ignored fields
	task automatic send_number(input logic [1:0] cmd, input logic [3:0] ulen,
			input logic [7:0] body[$]);
		for (int i = 0; i < body.size(); i++) begin
			if (i == 0)
				send_item(body[i], cmd, ulen);
			else
				send_item(body[i], 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
		end
	endtask

	// Accepted items on both sides
	always @(posedge clk) begin
		if (arst_n && push && !full)
			sb.note_byte(data_byte, command, uint_len);
		if (arst_n && pop && !empty) begin
			sb.check_result(value, num_bytes, status, unknown_size);
			results_taken++;
		end
	end

	// Watchdog on cycles with no progress on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Result side: random pops, one long hold-off to back up the queue
	initial begin
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!hold_done && results_taken >= HOLD_AFTER) begin
				gap = HOLD_CYCLES;
				hold_done = 1'b1;
			end else begin
				if ($urandom_range(0, 40) == 0)
					rx_calm = !rx_calm;
				gap = rx_calm ? 0 : $urandom_range(0, 10);
			end
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			@(negedge clk);
		end
	end

	initial begin
		logic [7:0] body[$];
		logic [7:0] marker;
		logic [7:0] first;
		logic [1:0] cmd;
		logic [3:0] ulen;
		int         kind;
		int         len;
		int         fill;
		bit         all_ones;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: extremes and every error path
		send_number(evd_pkg::MODE_ID, 4'd0, '{8'h81});
		send_number(evd_pkg::MODE_ID, 4'd15, '{8'h1A, 8'h45, 8'hDF, 8'hA3});
		send_number(evd_pkg::MODE_ID, 4'd1, '{8'h00});        // zero marker
		send_number(evd_pkg::MODE_ID, 4'd1, '{8'h08});        // id too long
		send_number(evd_pkg::MODE_LEN, 4'd0, '{8'hFF});       // unknown size, 1 byte
		send_number(evd_pkg::MODE_LEN, 4'd0, '{8'h80});
		send_number(evd_pkg::MODE_LEN, 4'd0, '{8'h00});       // zero marker
		send_number(evd_pkg::MODE_LEN, 4'd0,
			'{8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
		send_number(evd_pkg::MODE_UINT, 4'd1, '{8'hFF});
		send_number(evd_pkg::MODE_UINT, 4'd0, '{8'h5A});      // bad uint_len
		send_number(evd_pkg::MODE_UINT, 4'd9, '{8'hA5});
		send_number(evd_pkg::MODE_UINT, 4'd15, '{8'h33});
		send_number(CMD_RESERVED, 4'd4, '{8'h80});
		send_number(evd_pkg::MODE_UINT, 4'd2, '{8'hAB, 8'hCD});

		// Random: mostly well-formed numbers, some noise bytes
		while (items_sent < NUM_ITEMS) begin
			kind = $urandom_range(0, 99);
			body.delete();
			if (kind < 12) begin
				send_item(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
					4'($urandom_range(0, 15)));
			end else begin
				ulen = 4'($urandom_range(0, 15));
				all_ones = ($urandom_range(0, 3) == 0);
				if (kind < 40) begin
					cmd = evd_pkg::MODE_ID;
					len = $urandom_range(1, 4);
				end else if (kind < 70) begin
					cmd = evd_pkg::MODE_LEN;
					len = $urandom_range(1, 8);
				end else begin
					cmd = evd_pkg::MODE_UINT;
					len = $urandom_range(1, 8);
					ulen = 4'(len);
				end
				marker = 8'h80 >> (len - 1);
				fill = $urandom_range(0, 5);
				if (cmd == evd_pkg::MODE_UINT)
					first = (fill == 0) ? 8'hFF : (fill == 1) ? 8'h00 : 8'($urandom_range(0, 255));
				else if (cmd == evd_pkg::MODE_LEN && all_ones)
					first = marker | (marker - 8'd1);
				else
					first = marker | (8'($urandom_range(0, 255)) & (marker - 8'd1));
				body.push_back(first);
				for (int i = 1; i < len; i++) begin
					if ((cmd == evd_pkg::MODE_LEN && all_ones) ||
							(cmd == evd_pkg::MODE_UINT && fill == 0))
						body.push_back(8'hFF);
					else if (cmd == evd_pkg::MODE_UINT && fill == 1)
						body.push_back(8'h00);
					else
						body.push_back(8'($urandom_range(0, 255)));
				end
				send_number(cmd, ulen, body);
			end
		end
		@(negedge clk);
		push <= 1'b0;

		// Drain, then let anything stray arrive
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d bytes through id, length and fixed-width decoding; %0d results checked",
			sb.n_bytes, sb.n_checked);
		$display("Saw %0d error results and %0d unknown-size lengths, with a full-queue stall",
			sb.n_errors, sb.n_unknown);
		if (sb.fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
